FILE: design/gcr_pkg.sv
// Shared types and constants for the gripper ramp controller.
package gcr_pkg;

   localparam int unsigned POS_W    = 12;
   localparam int unsigned LOAD_W   = 11;
   localparam int unsigned THR_W    = 10;
   localparam int unsigned STEP_W   = 10;
   localparam int unsigned OPCODE_W = 3;
   localparam int unsigned CSR_AW   = 4;
   localparam int unsigned CSR_DW   = 32;

   localparam logic [POS_W-1:0]  OPEN_POS_RST  = 12'd1500;
   localparam logic [POS_W-1:0]  CLOSE_POS_RST = 12'd2351;
   localparam logic [THR_W-1:0]  LOAD_THR_RST  = 10'd285;
   localparam logic [STEP_W-1:0] STEP_SIZE_RST = 10'd40;

   typedef enum logic [1:0] {
      MODE_IDLE    = 2'd0,
      MODE_OPENING = 2'd1,
      MODE_CLOSING = 2'd2,
      MODE_HOLD    = 2'd3
   } mode_type;

   typedef enum logic [OPCODE_W-1:0] {
      OP_STEP       = 3'd0,
      OP_LOAD       = 3'd1,
      OP_CLOSE      = 3'd2,
      OP_HOLD       = 3'd3,
      OP_TORQUE_ON  = 3'd4,
      OP_TORQUE_OFF = 3'd5,
      OP_OPEN       = 3'd6
   } opcode_type;

   typedef enum logic [1:0] {
      REG_OPEN_POS  = 2'd0,
      REG_CLOSE_POS = 2'd1,
      REG_LOAD_THR  = 2'd2,
      REG_STEP_SIZE = 2'd3
   } reg_index_type;

endpackage

FILE: design/gripper_ramp_controller.sv
// Top level of the gripper ramp controller: request register, state update and result register.
//
// The controller takes one request per clock cycle while req_ready is high. Each request is a
// single event (step tick, load sample, or a close, hold, torque-on, torque-off or open
// command) and produces exactly one response. A request passes through the request register
// and then the response register before it is presented on the response port, where it is
// taken when rsp_ready is high. Requests are handled in order, since each one reads and
// writes the mode, target position and last-load registers. A request register and a
// response register separate the two channels, so one more request is still accepted
// while a finished response waits for rsp_ready; once both registers are full, req_ready
// stays low until the response is taken. The four configuration registers sit on an
// APB-style port at byte addresses 0x0 (open position), 0x4 (close position), 0x8 (load
// threshold) and 0xC (step size); they should be written only while no request is in
// flight.
module gripper_ramp_controller
   import gcr_pkg::*;
(
   input  logic                clock,
   input  logic                reset,

   input  logic                req_valid,
   output logic                req_ready,
   input  logic [OPCODE_W-1:0] req_opcode,
   input  logic signed [LOAD_W-1:0] req_load_sample,

   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_position_valid,
   output logic [POS_W-1:0]    rsp_position,
   output logic                rsp_torque_valid,
   output logic                rsp_torque_enable,
   output logic [1:0]          rsp_mode,
   output logic                rsp_grip_detected,

   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [CSR_AW-1:0]   csr_paddr,
   input  logic [CSR_DW-1:0]   csr_pwdata,
   output logic [CSR_DW-1:0]   csr_prdata,
   output logic                csr_pready
);

   // Configuration registers.
   logic [POS_W-1:0]  open_pos_ff;
   logic [POS_W-1:0]  close_pos_ff;
   logic [THR_W-1:0]  load_thr_ff;
   logic [STEP_W-1:0] step_size_ff;

   reg_index_type csr_index;
   logic          csr_write;

   assign csr_pready = 1'b1;
   assign csr_index  = reg_index_type'(csr_paddr[CSR_AW-1:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         open_pos_ff  <= OPEN_POS_RST;
         close_pos_ff <= CLOSE_POS_RST;
         load_thr_ff  <= LOAD_THR_RST;
         step_size_ff <= STEP_SIZE_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_OPEN_POS:  open_pos_ff  <= csr_pwdata[POS_W-1:0];
            REG_CLOSE_POS: close_pos_ff <= csr_pwdata[POS_W-1:0];
            REG_LOAD_THR:  load_thr_ff  <= csr_pwdata[THR_W-1:0];
            REG_STEP_SIZE: step_size_ff <= csr_pwdata[STEP_W-1:0];
            default: ;
         endcase
      end
   end

   // Reads return the register zero-extended to the bus width.
   always_comb begin
      unique case (csr_index)
         REG_OPEN_POS:  csr_prdata = {{(CSR_DW-POS_W){1'b0}}, open_pos_ff};
         REG_CLOSE_POS: csr_prdata = {{(CSR_DW-POS_W){1'b0}}, close_pos_ff};
         REG_LOAD_THR:  csr_prdata = {{(CSR_DW-THR_W){1'b0}}, load_thr_ff};
         REG_STEP_SIZE: csr_prdata = {{(CSR_DW-STEP_W){1'b0}}, step_size_ff};
         default:       csr_prdata = '0;
      endcase
   end

   // Pipeline control. The response register advances whenever it is empty or being
   // drained; the request register can then refill in the same cycle.
   logic                     s1_valid_ff;
   logic [OPCODE_W-1:0]      s1_opcode_ff;
   logic signed [LOAD_W-1:0] s1_load_ff;
   logic                     rsp_valid_ff;
   logic                     out_advance;
   logic                     fire;

   assign out_advance = !rsp_valid_ff || rsp_ready;
   assign req_ready   = !s1_valid_ff || out_advance;
   assign fire        = s1_valid_ff && out_advance;
   assign rsp_valid   = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         s1_opcode_ff <= req_opcode;
         s1_load_ff   <= req_load_sample;
      end
   end

   // Controller state.
   mode_type                 mode_ff, mode_in;
   logic [POS_W-1:0]         target_ff, target_in;
   logic signed [LOAD_W-1:0] last_load_ff, last_load_in;
   opcode_type               opcode;

   assign opcode = opcode_type'(s1_opcode_ff);

   // Ramp arithmetic. The downward sum carries two extra bits so that a step past zero
   // compares as negative; the upward sum carries one so that it cannot wrap.
   logic [POS_W+1:0]  dn_sum;
   logic [POS_W:0]    up_sum;
   logic              open_move;
   logic              close_move;
   logic [POS_W-1:0]  dn_target;
   logic [POS_W-1:0]  up_target;
   logic [POS_W-1:0]  close_next;
   logic [LOAD_W-1:0] load_mag;
   logic              grip_hit;
   logic              limit_hit;

   assign dn_sum     = {2'b00, target_ff} - {{(POS_W+2-STEP_W){1'b0}}, step_size_ff};
   assign up_sum     = {1'b0, target_ff} + {{(POS_W+1-STEP_W){1'b0}}, step_size_ff};
   assign open_move  = target_ff > open_pos_ff;
   assign close_move = target_ff < close_pos_ff;
   assign dn_target  = ($signed(dn_sum) > $signed({2'b00, open_pos_ff})) ?
                       dn_sum[POS_W-1:0] : open_pos_ff;
   assign up_target  = (up_sum < {1'b0, close_pos_ff}) ? up_sum[POS_W-1:0] : close_pos_ff;
   assign close_next = close_move ? up_target : target_ff;

   // The magnitude of -1024 is 1024, which still fits in the unsigned 11-bit view.
   assign load_mag  = last_load_ff[LOAD_W-1] ? LOAD_W'(-last_load_ff) : last_load_ff;
   assign grip_hit  = load_mag >= {{(LOAD_W-THR_W){1'b0}}, load_thr_ff};
   assign limit_hit = close_next >= close_pos_ff;

   // Next mode and grip flag.
   logic grip_in;

   always_comb begin
      mode_in = mode_ff;
      grip_in = 1'b0;
      case (opcode)
         OP_STEP: begin
            if (mode_ff == MODE_OPENING) begin
               if (!open_move) begin
                  mode_in = MODE_IDLE;
               end
            end else if (mode_ff == MODE_CLOSING) begin
               if (grip_hit) begin
                  grip_in = 1'b1;
               end
               if (grip_hit || limit_hit) begin
                  mode_in = MODE_HOLD;
               end
            end
         end
         OP_CLOSE:      mode_in = MODE_CLOSING;
         OP_HOLD:       mode_in = MODE_HOLD;
         OP_TORQUE_OFF: mode_in = MODE_IDLE;
         OP_OPEN:       mode_in = MODE_OPENING;
         default: ;
      endcase
   end

   // Target, load and command outputs. The target never leaves 0..4095, so the position
   // clamp reduces to passing the new target through.
   logic             pos_valid_in;
   logic [POS_W-1:0] pos_in;
   logic             tq_valid_in;
   logic             tq_en_in;

   always_comb begin
      target_in    = target_ff;
      last_load_in = last_load_ff;
      pos_valid_in = 1'b0;
      pos_in       = '0;
      tq_valid_in  = 1'b0;
      tq_en_in     = 1'b0;
      case (opcode) inside
         OP_STEP: begin
            if (mode_ff == MODE_OPENING && open_move) begin
               target_in    = dn_target;
               pos_valid_in = 1'b1;
               pos_in       = dn_target;
            end else if (mode_ff == MODE_CLOSING && close_move) begin
               target_in    = up_target;
               pos_valid_in = 1'b1;
               pos_in       = up_target;
            end
         end
         OP_LOAD: last_load_in = s1_load_ff;
         OP_CLOSE, OP_TORQUE_ON: begin
            tq_valid_in = 1'b1;
            tq_en_in    = 1'b1;
         end
         OP_TORQUE_OFF: tq_valid_in = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_IDLE;
         target_ff    <= OPEN_POS_RST;
         last_load_ff <= '0;
      end else if (fire) begin
         mode_ff      <= mode_in;
         target_ff    <= target_in;
         last_load_ff <= last_load_in;
      end
   end

   // Response register.
   logic             rsp_pos_valid_ff;
   logic [POS_W-1:0] rsp_pos_ff;
   logic             rsp_tq_valid_ff;
   logic             rsp_tq_en_ff;
   mode_type         rsp_mode_ff;
   logic             rsp_grip_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_advance) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_pos_valid_ff <= pos_valid_in;
         rsp_pos_ff       <= pos_in;
         rsp_tq_valid_ff  <= tq_valid_in;
         rsp_tq_en_ff     <= tq_en_in;
         rsp_mode_ff      <= mode_in;
         rsp_grip_ff      <= grip_in;
      end
   end

   assign rsp_position_valid = rsp_pos_valid_ff;
   assign rsp_position       = rsp_pos_ff;
   assign rsp_torque_valid   = rsp_tq_valid_ff;
   assign rsp_torque_enable  = rsp_tq_en_ff;
   assign rsp_mode           = rsp_mode_ff;
   assign rsp_grip_detected  = rsp_grip_ff;

   // A position command only comes from a ramping step, which never ends in idle.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_position_valid |-> rsp_mode != MODE_IDLE)
      else $error("position command with idle mode");

   // A detected grip always lands in hold and comes from a step, not a torque command.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_grip_detected |-> rsp_mode == MODE_HOLD && !rsp_torque_valid)
      else $error("grip flag without hold");

   // Position and torque commands come from different request kinds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_position_valid && rsp_torque_valid))
      else $error("position and torque command in one response");

   // The controller state only moves when a request is processed.
   assert property (@(posedge clock) disable iff (reset)
      !fire |=> $stable(mode_ff) && $stable(target_ff) && $stable(last_load_ff))
      else $error("state changed without a request");

endmodule
